// ===== src/coincidence_trigger_capture_assert.svh =====
// assertion macros for the coincidence trigger capture block
// used by the top level; expects clk and rst_n in scope
`ifndef COINCIDENCE_TRIGGER_CAPTURE_ASSERT_SVH
`define COINCIDENCE_TRIGGER_CAPTURE_ASSERT_SVH

// same-cycle implication
`define CTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("coincidence trigger capture assertion failed");

// next-cycle implication
`define CTC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("coincidence trigger capture assertion failed");

`endif

// ===== src/ctc_pkg.sv =====
// shared types and constants for the coincidence trigger capture block
// no dependencies
package ctc_pkg;

  localparam int CTC_CHANNELS   = 4;
  localparam int CTC_SAMPLES    = 16;
  localparam int CTC_SAMPLE_W   = 16;
  localparam int CTC_DATA_W     = CTC_SAMPLES * CTC_SAMPLE_W;
  localparam int CTC_CH_W       = 2;
  localparam int CTC_WIN_W      = 8;
  localparam int CTC_CNT_W      = 32;
  localparam int CTC_NUM_THR    = 4;
  localparam int CTC_ADDR_W     = 5;
  localparam int CTC_PDATA_W    = 32;

  typedef enum logic [2:0] {
    REG_THR_CH0  = 3'd0,
    REG_THR_CH1  = 3'd1,
    REG_THR_CH2  = 3'd2,
    REG_THR_CH3  = 3'd3,
    REG_WIN_LEN  = 3'd4,
    REG_PKT_LEN  = 3'd5
  } ctc_reg_e;

  typedef struct packed {
    logic [CTC_CH_W-1:0]   channel;
    logic [CTC_DATA_W-1:0] samples;
    logic                  last;
    logic                  clear;
  } ctc_item_t;

  typedef struct packed {
    logic [CTC_CH_W-1:0]   channel;
    logic [CTC_DATA_W-1:0] samples;
    logic                  last;
    logic                  triggered;
    logic [CTC_CNT_W-1:0]  trigger_beat;
  } ctc_result_t;

  typedef struct packed {
    logic                 trig;
    logic [CTC_CNT_W-1:0] latched;
    logic [CTC_CNT_W-1:0] beat;
  } ctc_status_t;

endpackage

// ===== src/ctc_lane.sv =====
// one sample lane: wrapped absolute value compared against the channel threshold
// depends on ctc_pkg
module ctc_lane
  import ctc_pkg::*;
(
  input  logic signed [CTC_SAMPLE_W-1:0] sample,
  input  logic signed [CTC_SAMPLE_W-1:0] thr,
  output logic                           hit
);

  logic signed [CTC_SAMPLE_W-1:0] mag;

  // most negative sample wraps back to itself
  assign mag = sample[CTC_SAMPLE_W-1] ? CTC_SAMPLE_W'(-sample) : sample;
  assign hit = mag > thr;

endmodule

// ===== src/ctc_core.sv =====
// merge of lane hits, window counters, sticky trigger and packet counter
// depends on ctc_pkg
module ctc_core
  import ctc_pkg::*;
#(
  parameter int CHANNELS = CTC_CHANNELS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  ctc_item_t              item,
  input  logic [CTC_SAMPLES-1:0] lane_hit,
  input  logic [CTC_WIN_W-1:0]   win_len,
  input  logic [CTC_CNT_W-1:0]   pkt_len,
  output ctc_result_t            res,
  output ctc_status_t            status
);

  logic [CTC_WIN_W-1:0] win_cnt_r   [CHANNELS];
  logic [CTC_WIN_W-1:0] win_cnt_nxt [CHANNELS];
  logic                 trig_r, trig_nxt;
  logic [CTC_CNT_W-1:0] beat_r, beat_nxt;
  logic [CTC_CNT_W-1:0] latched_r, latched_nxt;
  logic [CTC_CNT_W-1:0] pkt_cnt_r, pkt_cnt_nxt;
  logic [CTC_CNT_W-1:0] pkt_cnt_base;
  logic                 clr, gen_on, gen_last, last, hit, all_nz, is_last_ch;

  always_comb begin
    clr          = (item.channel == '0) && item.clear;
    trig_nxt     = clr ? 1'b0 : trig_r;
    pkt_cnt_base = clr ? '0 : pkt_cnt_r;
    gen_on       = pkt_len != '0;
    gen_last     = pkt_cnt_base == (pkt_len - CTC_CNT_W'(1));
    last         = gen_on ? gen_last : item.last;
    hit          = |lane_hit;
    is_last_ch   = item.channel == CTC_CH_W'(CHANNELS - 1);
    all_nz       = 1'b1;
    for (int k = 0; k < CHANNELS; k++) begin
      win_cnt_nxt[k] = win_cnt_r[k];
      if (item.channel == CTC_CH_W'(k)) begin
        if (hit) begin
          win_cnt_nxt[k] = win_len;
        end else if (win_cnt_r[k] != '0) begin
          win_cnt_nxt[k] = win_cnt_r[k] - CTC_WIN_W'(1);
        end
      end
      if (win_cnt_nxt[k] == '0) begin
        all_nz = 1'b0;
      end
    end
    latched_nxt = latched_r;
    beat_nxt    = beat_r;
    pkt_cnt_nxt = pkt_cnt_base;
    if (is_last_ch) begin
      if (!trig_nxt && all_nz) begin
        trig_nxt    = 1'b1;
        latched_nxt = beat_r;
      end
      if (gen_on) begin
        pkt_cnt_nxt = gen_last ? '0 : pkt_cnt_base + CTC_CNT_W'(1);
      end
      beat_nxt = beat_r + CTC_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CHANNELS; k++) begin
        win_cnt_r[k] <= '0;
      end
      trig_r    <= 1'b0;
      beat_r    <= '0;
      latched_r <= '0;
      pkt_cnt_r <= '0;
    end else if (accept) begin
      for (int k = 0; k < CHANNELS; k++) begin
        win_cnt_r[k] <= win_cnt_nxt[k];
      end
      trig_r    <= trig_nxt;
      beat_r    <= beat_nxt;
      latched_r <= latched_nxt;
      pkt_cnt_r <= pkt_cnt_nxt;
    end
  end

  always_comb begin
    res.channel      = item.channel;
    res.samples      = item.samples;
    res.last         = last;
    res.triggered    = trig_nxt;
    res.trigger_beat = latched_nxt;
  end

  assign status = '{trig: trig_r, latched: latched_r, beat: beat_r};

endmodule

// ===== src/coincidence_trigger_capture.sv =====
// coincidence trigger capture: top level with config registers, sample lanes and output buffer
// depends on ctc_pkg, ctc_lane, ctc_core and coincidence_trigger_capture_assert.svh

// Takes one channel beat of sixteen 16-bit samples per clock and returns it
// registered, with the packet end mark, the sticky trigger flag and the latched
// beat index. Sixteen lanes compare sample magnitudes against the threshold of
// the beat's channel in parallel; the window counters, trigger and packet counter
// update in an unpipelined loop, so a new transaction is taken every clock while
// the output side keeps up. A two-entry output buffer (output register plus skid
// register) lets in_tready depend only on registered state; the block stalls input
// only when both entries hold untaken results. Config writes go through the APB
// port and should happen while the stream is idle.
module coincidence_trigger_capture
  import ctc_pkg::*;
#(
  parameter int CHANNELS = CTC_CHANNELS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: channel[1:0], word0[65:2], word1[129:66], word2[193:130],
  // word3[257:194], zero pad
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [263:0]           in_tdata,
  input  logic                   in_tlast,
  input  logic                   in_tuser,  // clear
  // out_tdata: out_channel[1:0], out_word0..3[257:2], triggered[258],
  // trigger_beat[290:259], zero pad
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [295:0]           out_tdata,
  output logic                   out_tlast,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CTC_ADDR_W-1:0]  cfg_paddr,
  input  logic [CTC_PDATA_W-1:0] cfg_pwdata,
  output logic [CTC_PDATA_W-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  logic [CTC_SAMPLE_W-1:0] thr_r [CTC_NUM_THR];
  logic [CTC_WIN_W-1:0]    win_len_r;
  logic [CTC_CNT_W-1:0]    pkt_len_r;
  logic                    cfg_wr;
  ctc_reg_e                cfg_reg;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_reg    = ctc_reg_e'(cfg_paddr[CTC_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CTC_NUM_THR; k++) begin
        thr_r[k] <= '0;
      end
      win_len_r <= '0;
      pkt_len_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_reg)
        REG_THR_CH0: thr_r[0] <= cfg_pwdata[CTC_SAMPLE_W-1:0];
        REG_THR_CH1: thr_r[1] <= cfg_pwdata[CTC_SAMPLE_W-1:0];
        REG_THR_CH2: thr_r[2] <= cfg_pwdata[CTC_SAMPLE_W-1:0];
        REG_THR_CH3: thr_r[3] <= cfg_pwdata[CTC_SAMPLE_W-1:0];
        REG_WIN_LEN: win_len_r <= cfg_pwdata[CTC_WIN_W-1:0];
        REG_PKT_LEN: pkt_len_r <= cfg_pwdata[CTC_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg)
      REG_THR_CH0: cfg_prdata = CTC_PDATA_W'(thr_r[0]);
      REG_THR_CH1: cfg_prdata = CTC_PDATA_W'(thr_r[1]);
      REG_THR_CH2: cfg_prdata = CTC_PDATA_W'(thr_r[2]);
      REG_THR_CH3: cfg_prdata = CTC_PDATA_W'(thr_r[3]);
      REG_WIN_LEN: cfg_prdata = CTC_PDATA_W'(win_len_r);
      REG_PKT_LEN: cfg_prdata = pkt_len_r;
      default:     cfg_prdata = '0;
    endcase
  end

  ctc_item_t               item;
  logic                    accept;
  logic [CTC_SAMPLE_W-1:0] thr_sel;
  logic [CTC_SAMPLES-1:0]  lane_hit;
  ctc_result_t             res;
  ctc_status_t             status;

  assign item.channel = in_tdata[CTC_CH_W-1:0];
  assign item.samples = in_tdata[CTC_CH_W +: CTC_DATA_W];
  assign item.last    = in_tlast;
  assign item.clear   = in_tuser;
  assign accept       = in_tvalid && in_tready;
  assign thr_sel      = thr_r[item.channel];

  for (genvar i = 0; i < CTC_SAMPLES; i++) begin : g_lane
    ctc_lane u_lane (
      .sample (item.samples[i*CTC_SAMPLE_W +: CTC_SAMPLE_W]),
      .thr    (thr_sel),
      .hit    (lane_hit[i])
    );
  end

  ctc_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (item),
    .lane_hit (lane_hit),
    .win_len  (win_len_r),
    .pkt_len  (pkt_len_r),
    .res      (res),
    .status   (status)
  );

  // output register plus skid register
  logic        out_valid_r, skid_valid_r;
  ctc_result_t out_data_r, skid_data_r;

  assign in_tready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && !out_tready) begin
      if (accept) begin
        skid_valid_r <= 1'b1;
      end
    end else begin
      out_valid_r  <= skid_valid_r || accept;
      skid_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && !out_tready) begin
      if (accept) begin
        skid_data_r <= res;
      end
    end else if (skid_valid_r) begin
      out_data_r <= skid_data_r;
    end else if (accept) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_data_r.last;
  assign out_tdata  = {5'd0, out_data_r.trigger_beat, out_data_r.triggered,
                       out_data_r.samples, out_data_r.channel};

`include "coincidence_trigger_capture_assert.svh"

  `CTC_ASSERT_IMP(a_skid_needs_out, skid_valid_r, out_valid_r)
  `CTC_ASSERT_NXT(a_stall_fills_skid, accept && out_valid_r && !out_tready, skid_valid_r)
  `CTC_ASSERT_IMP(a_trig_latches_beat, $rose(status.trig), status.latched == $past(status.beat))

endmodule

// ===== sim/tb_coincidence_trigger_capture.sv =====
`timescale 1ns / 1ps
// testbench for coincidence_trigger_capture: directed and random channel beats checked
// against an in-bench model of window counters, sticky trigger and packet end marks
// depends on ctc_pkg and the coincidence_trigger_capture rtl
module tb_coincidence_trigger_capture;
  import ctc_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASE_ITEMS  = 400;
  localparam int MAX_PRINTED  = 100;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [263:0]           in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [295:0]           out_tdata;
  logic                   out_tlast;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CTC_ADDR_W-1:0]  cfg_paddr = '0;
  logic [CTC_PDATA_W-1:0] cfg_pwdata = '0;
  logic [CTC_PDATA_W-1:0] cfg_prdata;
  logic                   cfg_pready;

  coincidence_trigger_capture uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // model registers and state
  logic signed [15:0] thr_q [CTC_CHANNELS];
  logic [7:0]         win_len_q;
  logic [31:0]        pkt_len_q;
  logic [7:0]         win_cnt [CTC_CHANNELS];
  bit                 trig_q;
  logic [31:0]        beat_idx;
  logic [31:0]        latched_idx;
  logic [31:0]        pkt_cnt;

  ctc_item_t   pending_items[$];
  ctc_result_t expected_beats[$];
  ctc_item_t   drive_item;

  int queued_total = 0;
  int offered_items = 0;
  int accepted_items = 0;
  int beats_checked = 0;
  int errors = 0;
  int trigger_events = 0;
  int packet_ends = 0;
  int settings_used = 0;
  int send_gap = 0;
  int send_calm = 0;
  int recv_calm = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;

  function automatic bit beat_exceeds(logic [255:0] s, logic signed [15:0] thr);
    int v;
    int a;
    bit hit;
    hit = 1'b0;
    for (int k = 0; k < CTC_SAMPLES; k++) begin
      v = int'($signed(s[16*k +: 16]));
      a = (v < 0) ? -v : v;
      if (a > 32767) a -= 65536;
      if (a > int'(thr)) hit = 1'b1;
    end
    return hit;
  endfunction

  task automatic advance_capture(input ctc_item_t it);
    ctc_result_t r;
    bit          wrap;
    bit          all_open;
    if (it.channel == 0 && it.clear) begin
      trig_q  = 1'b0;
      pkt_cnt = '0;
    end
    wrap   = (pkt_len_q != 0) && (pkt_cnt == pkt_len_q - 32'd1);
    r.last = (pkt_len_q != 0) ? wrap : it.last;
    if (beat_exceeds(it.samples, thr_q[it.channel]))
      win_cnt[it.channel] = win_len_q;
    else if (win_cnt[it.channel] != 0)
      win_cnt[it.channel]--;
    if (it.channel == CTC_CHANNELS - 1) begin
      all_open = 1'b1;
      for (int k = 0; k < CTC_CHANNELS; k++)
        if (win_cnt[k] == 0) all_open = 1'b0;
      if (!trig_q && all_open) begin
        trig_q      = 1'b1;
        latched_idx = beat_idx;
        trigger_events++;
      end
      if (pkt_len_q != 0) pkt_cnt = wrap ? 32'd0 : pkt_cnt + 32'd1;
      beat_idx = beat_idx + 32'd1;
    end
    r.channel      = it.channel;
    r.samples      = it.samples;
    r.triggered    = trig_q;
    r.trigger_beat = latched_idx;
    expected_beats.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    if (errors <= MAX_PRINTED)
      $display("mismatch in %s at result %0d: got %h want %h", what, beats_checked, got, want);
  endtask

  // mostly short gaps, a few long ones, and calm stretches with none
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 20) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 650) return 0;
    if (r < 950) return $urandom_range(1, 3);
    if (r < 997) return $urandom_range(8, 40);
    return $urandom_range(60, 150);
  endfunction

  // sender
  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && accepted_items != offered_items)) begin
      if (send_gap > 0) begin
        in_tvalid <= 1'b0;
        send_gap--;
      end else if (pending_items.size() != 0) begin
        drive_item = pending_items.pop_front();
        in_tdata  <= {6'b0, drive_item.samples, drive_item.channel};
        in_tlast  <= drive_item.last;
        in_tuser  <= drive_item.clear;
        in_tvalid <= 1'b1;
        offered_items++;
        send_gap = pick_gap(send_calm);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with one forced long hold-off while input keeps arriving
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (!long_hold_done && beats_checked >= 700) begin
      long_hold_done = 1'b1;
      hold_left = 240;
      out_tready <= 1'b0;
    end else begin
      hold_left = pick_gap(recv_calm);
      out_tready <= (hold_left == 0);
      if (hold_left > 0) hold_left--;
    end
  end

  // input acceptance and result checking
  always @(posedge clk) begin
    ctc_result_t got;
    ctc_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        advance_capture(drive_item);
        accepted_items++;
      end
      if (out_tvalid && out_tready) begin
        got.channel      = out_tdata[1:0];
        got.samples      = out_tdata[257:2];
        got.triggered    = out_tdata[258];
        got.trigger_beat = out_tdata[290:259];
        got.last         = out_tlast;
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected transaction", 64'(got.channel), 64'd0);
        end else begin
          want = expected_beats.pop_front();
          if (want.last) packet_ends++;
          if (got.channel != want.channel)
            report_mismatch("channel", 64'(got.channel), 64'(want.channel));
          for (int w = 0; w < 4; w++)
            if (got.samples[64*w +: 64] != want.samples[64*w +: 64])
              report_mismatch($sformatf("word%0d", w), got.samples[64*w +: 64],
                              want.samples[64*w +: 64]);
          if (got.last != want.last)
            report_mismatch("last", 64'(got.last), 64'(want.last));
          if (got.triggered != want.triggered)
            report_mismatch("triggered", 64'(got.triggered), 64'(want.triggered));
          if (got.trigger_beat != want.trigger_beat)
            report_mismatch("trigger_beat", 64'(got.trigger_beat), 64'(want.trigger_beat));
        end
        beats_checked++;
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
             expected_beats.size());
    $display("FAILURE");
    $finish;
  end

  task automatic write_reg(ctc_reg_e idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_THR_CH0, REG_THR_CH1, REG_THR_CH2, REG_THR_CH3: thr_q[idx] = val[15:0];
      REG_WIN_LEN: win_len_q = val[7:0];
      REG_PKT_LEN: pkt_len_q = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(int t0, int t1, int t2, int t3, int win, logic [31:0] pkt);
    write_reg(REG_THR_CH0, 32'(t0));
    write_reg(REG_THR_CH1, 32'(t1));
    write_reg(REG_THR_CH2, 32'(t2));
    write_reg(REG_THR_CH3, 32'(t3));
    write_reg(REG_WIN_LEN, 32'(win));
    write_reg(REG_PKT_LEN, pkt);
    settings_used++;
  endtask

  task automatic wait_drained();
    while (accepted_items != queued_total || expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_item(logic [1:0] ch, logic [255:0] s, logic last, logic clr);
    ctc_item_t it;
    it.channel = ch;
    it.samples = s;
    it.last    = last;
    it.clear   = clr;
    pending_items.push_back(it);
    queued_total++;
  endtask

  function automatic logic [255:0] random_samples();
    logic [255:0] s;
    for (int k = 0; k < 8; k++) s[32*k +: 32] = $urandom();
    return s;
  endfunction

  // quiet samples around the threshold, sometimes one spike, sometimes full noise
  function automatic logic [255:0] beat_samples(logic signed [15:0] thr);
    logic [255:0] s;
    int           mode;
    int           t;
    int           k;
    t = int'(thr);
    mode = $urandom_range(0, 99);
    for (int j = 0; j < CTC_SAMPLES; j++)
      s[16*j +: 16] = (t >= 0) ? 16'(int'($urandom_range(0, 2 * t)) - t) : 16'h8000;
    if (mode >= 85) begin
      s = random_samples();
    end else if (mode >= 45) begin
      k = $urandom_range(0, CTC_SAMPLES - 1);
      case ($urandom_range(0, 4))
        0: s[16*k +: 16] = 16'(t + 1);
        1: s[16*k +: 16] = 16'(-(t + 1));
        2: s[16*k +: 16] = 16'h7FFF;
        3: s[16*k +: 16] = 16'h8001;
        default: s[16*k +: 16] = 16'($urandom());
      endcase
    end
    return s;
  endfunction

  task automatic queue_beat_item(logic [1:0] ch);
    logic clr;
    clr = (ch == 0) ? ($urandom_range(0, 15) == 0) : ($urandom_range(0, 31) == 0);
    queue_item(ch, beat_samples(thr_q[ch]), $urandom_range(0, 3) == 0, clr);
  endtask

  task automatic run_random_phase(int n);
    int start;
    int r;
    int skip;
    start = queued_total;
    while (queued_total - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        queue_item(2'($urandom()), random_samples(), 1'($urandom()), 1'($urandom()));
      end else if (r < 10) begin
        // broken beat: one channel dropped, or replaced by a random channel
        skip = $urandom_range(0, CTC_CHANNELS - 1);
        for (int c = 0; c < CTC_CHANNELS; c++)
          if (c != skip) queue_beat_item(2'(c));
          else if ($urandom_range(0, 1)) queue_beat_item(2'($urandom_range(0, 3)));
      end else begin
        for (int c = 0; c < CTC_CHANNELS; c++) queue_beat_item(2'(c));
      end
    end
    wait_drained();
  endtask

  initial begin
    for (int c = 0; c < CTC_CHANNELS; c++) begin
      thr_q[c]   = '0;
      win_cnt[c] = '0;
    end
    win_len_q   = '0;
    pkt_len_q   = '0;
    trig_q      = 1'b0;
    beat_idx    = '0;
    latched_idx = '0;
    pkt_cnt     = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed beats
    apply_setting(0, 0, 0, 0, 2, 32'd0);
    for (int c = 0; c < CTC_CHANNELS; c++) queue_item(2'(c), '0, c == 3, 1'b0);
    for (int c = 0; c < CTC_CHANNELS; c++)
      queue_item(2'(c), {CTC_SAMPLES{16'h8000}}, c == 0, 1'b0);
    for (int c = 0; c < CTC_CHANNELS; c++) queue_item(2'(c), '1, 1'b1, 1'b0);
    // clear on channel 0 honoured, clear on channel 2 ignored
    queue_item(2'd0, {CTC_SAMPLES{16'h7FFF}}, 1'b0, 1'b1);
    queue_item(2'd1, '0, 1'b0, 1'b0);
    queue_item(2'd2, '0, 1'b1, 1'b1);
    queue_item(2'd3, {CTC_SAMPLES{16'h0001}}, 1'b0, 1'b0);
    // channels out of order
    queue_item(2'd3, random_samples(), 1'b0, 1'b0);
    queue_item(2'd1, random_samples(), 1'b1, 1'b1);
    queue_item(2'd0, random_samples(), 1'b0, 1'b1);
    queue_item(2'd2, random_samples(), 1'b0, 1'b0);
    wait_drained();

    apply_setting(100, 200, 300, 400, 4, 32'd0);
    run_random_phase(PHASE_ITEMS);
    apply_setting(-32768, -1, 0, 1000, 255, 32'd1);
    run_random_phase(PHASE_ITEMS);
    apply_setting(int'($urandom_range(0, 3050)) - 50, int'($urandom_range(0, 3050)) - 50,
                  int'($urandom_range(0, 3050)) - 50, int'($urandom_range(0, 3050)) - 50,
                  $urandom_range(1, 8), 32'd3);
    run_random_phase(PHASE_ITEMS);
    apply_setting(32767, 32767, 32767, 32767, 0, 32'hFFFF_FFFF);
    run_random_phase(PHASE_ITEMS);
    apply_setting(int'($urandom_range(0, 3050)) - 50, int'($urandom_range(0, 3050)) - 50,
                  int'($urandom_range(0, 3050)) - 50, int'($urandom_range(0, 3050)) - 50,
                  $urandom_range(0, 255), 32'($urandom_range(1, 20)));
    run_random_phase(PHASE_ITEMS);

    repeat (10) @(posedge clk);
    $display("checked %0d results over %0d register settings", beats_checked, settings_used);
    $display("saw %0d trigger events and %0d packet end marks, %0d mismatches",
             trigger_events, packet_ends, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/ctc_pkg.sv
src/ctc_lane.sv
src/ctc_core.sv
src/coincidence_trigger_capture.sv
sim/tb_coincidence_trigger_capture.sv
